/* hw/rtl/ptc_pkg.sv */
// Package with shared types, constants and helper functions for the compensation core.
package ptc_pkg;

   localparam int DivSteps = 32;

   localparam logic [1:0] CsrCoefA = 2'd0;
   localparam logic [1:0] CsrCoefB = 2'd1;
   localparam logic [1:0] CsrCoefC = 2'd2;
   localparam logic [1:0] CsrOss   = 2'd3;

   localparam logic [31:0] B6Offset   = 32'd4000;
   localparam logic [31:0] CompC1     = 32'd3038;
   localparam logic [31:0] CompC2     = 32'hFFFF_E343;
   localparam logic [31:0] CompC3     = 32'd3791;
   localparam logic [31:0] B7Scale    = 32'd50000;
   localparam logic [31:0] B4Bias     = 32'd32768;
   localparam logic [31:0] SignBit    = 32'h8000_0000;
   localparam logic [31:0] TempMax    = 32'd1000;
   localparam logic [31:0] TempMin    = 32'hFFFF_FC18;
   localparam logic [31:0] PressMax   = 32'd262143;

   typedef struct packed {
      logic        valid;
      logic        temp_err;
      logic        press_err;
      logic [23:0] up;
      logic [31:0] x1;
      logic [31:0] b5;
      logic [10:0] tenths;
      logic [31:0] p;
   } ctx_type;

   function automatic logic [31:0] asr32(logic [31:0] v, int unsigned n);
      return 32'($signed(v) >>> n);
   endfunction

   function automatic logic [31:0] sext16(logic [15:0] v);
      return {{16{v[15]}}, v};
   endfunction

endpackage

/* hw/rtl/ptc_div_pipe.sv */
// Pipelined unsigned 32-bit restoring divider, one quotient bit per stage, with sideband.
module ptc_div_pipe (
   input  logic             clock,
   input  logic             reset,
   input  logic             adv,
   input  logic [31:0]      num,
   input  logic [31:0]      den,
   input  ptc_pkg::ctx_type ctx_in,
   output logic [31:0]      quo,
   output ptc_pkg::ctx_type ctx_out
);
   import ptc_pkg::*;

   logic [31:0] rem_ff [DivSteps];
   logic [31:0] quo_ff [DivSteps];
   logic [31:0] den_ff [DivSteps];
   ctx_type     ctx_ff [DivSteps];

   for (genvar k = 0; k < DivSteps; k++) begin : g_step
      logic [31:0] prev_rem;
      logic [31:0] prev_quo;
      logic [31:0] prev_den;
      ctx_type     prev_ctx;
      logic [32:0] trial;
      logic [33:0] diff;
      logic        ge;
      logic [31:0] rem_in;
      logic [31:0] quo_in;

      if (k == 0) begin : g_first
         assign prev_rem = '0;
         assign prev_quo = num;
         assign prev_den = den;
         assign prev_ctx = ctx_in;
      end else begin : g_next
         assign prev_rem = rem_ff[k-1];
         assign prev_quo = quo_ff[k-1];
         assign prev_den = den_ff[k-1];
         assign prev_ctx = ctx_ff[k-1];
      end

      always_comb begin
         trial  = {prev_rem, prev_quo[31]};
         diff   = {1'b0, trial} - {2'b00, prev_den};
         ge     = ~diff[33];
         rem_in = ge ? diff[31:0] : trial[31:0];
         quo_in = {prev_quo[30:0], ge};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            ctx_ff[k].valid <= 1'b0;
         end else if (adv) begin
            ctx_ff[k] <= prev_ctx;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[k] <= rem_in;
            quo_ff[k] <= quo_in;
            den_ff[k] <= prev_den;
         end
      end
   end

   assign quo     = quo_ff[DivSteps-1];
   assign ctx_out = ctx_ff[DivSteps-1];

endmodule

/* hw/rtl/pressure_temp_compensation_core.sv */
// Top level of the barometric pressure and temperature compensation core.
// The core takes one transfer per cycle while req_stall is low; each result passes
// through a few stages of 32-bit multiply and shift around two
// pipelined 32-stage dividers, one for the temperature factor and one for pressure.
// When the result register is stalled the whole pipeline holds, and req_stall rises.
// Coefficients must be written while no transfer is in flight.
module pressure_temp_compensation_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [15:0] req_raw_temp_word,
   input  logic [23:0] req_raw_press_word,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic signed [10:0] rsp_temp_tenths,
   output logic signed [31:0] rsp_temp_factor,
   output logic [17:0] rsp_pressure_pa,
   output logic        rsp_div_error,
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_wr_data
);
   import ptc_pkg::*;

   logic [63:0] coef_a_ff;
   logic [63:0] coef_b_ff;
   logic [31:0] coef_c_ff;
   logic [1:0]  oss_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_a_ff <= '0;
         coef_b_ff <= '0;
         coef_c_ff <= '0;
         oss_ff    <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CsrCoefA: coef_a_ff <= csr_wr_data;
            CsrCoefB: coef_b_ff <= csr_wr_data;
            CsrCoefC: coef_c_ff <= csr_wr_data[31:0];
            CsrOss:   oss_ff    <= csr_wr_data[1:0];
            default:  coef_a_ff <= coef_a_ff;
         endcase
      end
   end

   logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
   assign ac1 = sext16(coef_a_ff[15:0]);
   assign ac2 = sext16(coef_a_ff[31:16]);
   assign ac3 = sext16(coef_a_ff[47:32]);
   assign ac4 = {16'd0, coef_a_ff[63:48]};
   assign ac5 = {16'd0, coef_b_ff[15:0]};
   assign ac6 = {16'd0, coef_b_ff[31:16]};
   assign b1  = sext16(coef_b_ff[47:32]);
   assign b2  = sext16(coef_b_ff[63:48]);
   assign mc  = sext16(coef_c_ff[15:0]);
   assign md  = sext16(coef_c_ff[31:16]);

   logic adv;
   assign adv       = ~rsp_valid | ~rsp_stall;
   assign req_stall = ~adv;

   // Stage 1: temperature product.
   ctx_type     s1_ctx_ff, s1_ctx_in;
   logic [31:0] s1_prod_ff, s1_prod_in;
   always_comb begin
      s1_ctx_in       = '0;
      s1_ctx_in.valid = req_valid;
      s1_ctx_in.up    = 24'(req_raw_press_word >> (4'd8 - {2'b00, oss_ff}));
      s1_prod_in      = 32'(({16'd0, req_raw_temp_word} - ac6) * ac5);
   end

   // Stage 2: divisor and operand conditioning.
   ctx_type     s2_ctx_ff, s2_ctx_in;
   logic [31:0] s2_num_ff, s2_num_in, s2_den_ff, s2_den_in;
   logic        s2_neg_ff, s2_neg_in;
   logic [31:0] s2_x1, s2_dv, s2_nm;
   always_comb begin
      s2_x1     = asr32(s1_prod_ff, 15);
      s2_dv     = s2_x1 + md;
      s2_nm     = mc << 11;
      s2_ctx_in = s1_ctx_ff;
      s2_ctx_in.x1       = s2_x1;
      s2_ctx_in.temp_err = (s2_dv == '0);
      s2_neg_in = s2_dv[31] ^ s2_nm[31];
      s2_num_in = s2_nm[31] ? (32'd0 - s2_nm) : s2_nm;
      s2_den_in = s2_dv[31] ? (32'd0 - s2_dv) : s2_dv;
   end

   ctx_type     d1_ctx;
   logic [31:0] d1_quo;
   ctx_type     d1_ctx_in;
   logic [31:0] d1_num_in;
   always_comb begin
      d1_ctx_in = s2_ctx_ff;
      d1_ctx_in.press_err = s2_neg_ff;
      d1_num_in = s2_num_ff;
   end

   ptc_div_pipe u_temp_div (
      .clock   (clock),
      .reset   (reset),
      .adv     (adv),
      .num     (d1_num_in),
      .den     (s2_den_ff),
      .ctx_in  (d1_ctx_in),
      .quo     (d1_quo),
      .ctx_out (d1_ctx)
   );

   // Stage 3: temperature factor.
   ctx_type s3_ctx_ff, s3_ctx_in;
   always_comb begin
      s3_ctx_in = d1_ctx;
      s3_ctx_in.press_err = 1'b0;
      s3_ctx_in.b5 = d1_ctx.x1 + (d1_ctx.press_err ? (32'd0 - d1_quo) : d1_quo);
   end

   // Stage 4: temperature clamp and first products.
   ctx_type     s4_ctx_ff, s4_ctx_in;
   logic [31:0] s4_b6_in, s4_sqp_ff, s4_sqp_in;
   logic [31:0] s4_a2_ff, s4_a2_in, s4_a3_ff, s4_a3_in;
   logic [31:0] s4_t;
   always_comb begin
      s4_ctx_in = s3_ctx_ff;
      s4_t      = asr32(s3_ctx_ff.b5 + 32'd8, 4);
      if ($signed(s4_t) > $signed(TempMax)) begin
         s4_ctx_in.tenths = TempMax[10:0];
      end else if ($signed(s4_t) < $signed(TempMin)) begin
         s4_ctx_in.tenths = TempMin[10:0];
      end else begin
         s4_ctx_in.tenths = s4_t[10:0];
      end
      s4_b6_in  = s3_ctx_ff.b5 - B6Offset;
      s4_sqp_in = 32'(s4_b6_in * s4_b6_in);
      s4_a2_in  = 32'(ac2 * s4_b6_in);
      s4_a3_in  = 32'(ac3 * s4_b6_in);
   end

   // Stage 5: scaled terms.
   ctx_type     s5_ctx_ff;
   logic [31:0] s5_sq_ff, s5_x2_ff, s5_x1c_ff;

   // Stage 6: coefficient products with the squared term.
   ctx_type     s6_ctx_ff;
   logic [31:0] s6_b2sq_ff, s6_b1sq_ff, s6_x2_ff, s6_x1c_ff;

   // Stage 7: b3 and the b4 operand.
   ctx_type     s7_ctx_ff;
   logic [31:0] s7_b3_ff, s7_b3_in, s7_x3p_ff, s7_x3p_in;
   logic [31:0] s7_x3a, s7_x3b;
   always_comb begin
      s7_x3a    = asr32(s6_b2sq_ff, 11) + s6_x2_ff;
      s7_b3_in  = asr32((((ac1 << 2) + s7_x3a) << oss_ff) + 32'd2, 2);
      s7_x3b    = asr32(s6_x1c_ff + asr32(s6_b1sq_ff, 16) + 32'd2, 2);
      s7_x3p_in = s7_x3b + B4Bias;
   end

   // Stage 8: b4 and b7.
   ctx_type     s8_ctx_ff;
   logic [31:0] s8_b4_ff, s8_b4_in, s8_b7_ff, s8_b7_in;
   always_comb begin
      s8_b4_in = 32'(ac4 * s7_x3p_ff) >> 15;
      s8_b7_in = 32'(({8'd0, s7_ctx_ff.up} - s7_b3_ff) * (B7Scale >> oss_ff));
   end

   // Stage 9: pressure divider operands.
   ctx_type     s9_ctx_ff, s9_ctx_in;
   logic [31:0] s9_num_ff, s9_num_in, s9_den_ff;
   logic        s9_big_ff, s9_big_in;
   always_comb begin
      s9_ctx_in = s8_ctx_ff;
      s9_ctx_in.press_err = (s8_b4_ff == '0);
      s9_big_in = (s8_b7_ff >= SignBit);
      s9_num_in = s9_big_in ? s8_b7_ff : (s8_b7_ff << 1);
   end

   ctx_type     d2_ctx, d2_ctx_in;
   logic [31:0] d2_quo;
   always_comb begin
      d2_ctx_in   = s9_ctx_ff;
      d2_ctx_in.p = {31'd0, s9_big_ff};
   end

   ptc_div_pipe u_press_div (
      .clock   (clock),
      .reset   (reset),
      .adv     (adv),
      .num     (s9_num_ff),
      .den     (s9_den_ff),
      .ctx_in  (d2_ctx_in),
      .quo     (d2_quo),
      .ctx_out (d2_ctx)
   );

   // Stage 10: pressure and correction products.
   ctx_type     s10_ctx_ff, s10_ctx_in;
   logic [31:0] s10_sq_ff, s10_sq_in, s10_m2_ff, s10_m2_in, s10_p8;
   always_comb begin
      s10_ctx_in   = d2_ctx;
      s10_ctx_in.p = d2_ctx.p[0] ? (d2_quo << 1) : d2_quo;
      s10_p8       = asr32(s10_ctx_in.p, 8);
      s10_sq_in    = 32'(s10_p8 * s10_p8);
      s10_m2_in    = 32'(CompC2 * s10_ctx_in.p);
   end

   // Stage 11: second correction product.
   ctx_type     s11_ctx_ff;
   logic [31:0] s11_m1_ff, s11_x2_ff;

   // Stage 12: final pressure and result register.
   logic [31:0] s12_x1, s12_comp;
   logic [17:0] s12_press;
   always_comb begin
      s12_x1   = asr32(s11_m1_ff, 16);
      s12_comp = s11_ctx_ff.p + asr32(s12_x1 + s11_x2_ff + CompC3, 4);
      if (s12_comp[31]) begin
         s12_press = '0;
      end else if (s12_comp > PressMax) begin
         s12_press = PressMax[17:0];
      end else begin
         s12_press = s12_comp[17:0];
      end
   end

   logic        rsp_valid_ff;
   logic [10:0] rsp_tenths_ff;
   logic [31:0] rsp_factor_ff;
   logic [17:0] rsp_press_ff;
   logic        rsp_err_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ctx_ff.valid  <= 1'b0;
         s2_ctx_ff.valid  <= 1'b0;
         s3_ctx_ff.valid  <= 1'b0;
         s4_ctx_ff.valid  <= 1'b0;
         s5_ctx_ff.valid  <= 1'b0;
         s6_ctx_ff.valid  <= 1'b0;
         s7_ctx_ff.valid  <= 1'b0;
         s8_ctx_ff.valid  <= 1'b0;
         s9_ctx_ff.valid  <= 1'b0;
         s10_ctx_ff.valid <= 1'b0;
         s11_ctx_ff.valid <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else if (adv) begin
         s1_ctx_ff    <= s1_ctx_in;
         s2_ctx_ff    <= s2_ctx_in;
         s3_ctx_ff    <= s3_ctx_in;
         s4_ctx_ff    <= s4_ctx_in;
         s5_ctx_ff    <= s4_ctx_ff;
         s6_ctx_ff    <= s5_ctx_ff;
         s7_ctx_ff    <= s6_ctx_ff;
         s8_ctx_ff    <= s7_ctx_ff;
         s9_ctx_ff    <= s9_ctx_in;
         s10_ctx_ff   <= s10_ctx_in;
         s11_ctx_ff   <= s10_ctx_ff;
         rsp_valid_ff <= s11_ctx_ff.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_prod_ff <= s1_prod_in;
         s2_num_ff  <= s2_num_in;
         s2_den_ff  <= s2_den_in;
         s2_neg_ff  <= s2_neg_in;
         s4_sqp_ff  <= s4_sqp_in;
         s4_a2_ff   <= s4_a2_in;
         s4_a3_ff   <= s4_a3_in;
         s5_sq_ff   <= asr32(s4_sqp_ff, 12);
         s5_x2_ff   <= asr32(s4_a2_ff, 11);
         s5_x1c_ff  <= asr32(s4_a3_ff, 13);
         s6_b2sq_ff <= 32'(b2 * s5_sq_ff);
         s6_b1sq_ff <= 32'(b1 * s5_sq_ff);
         s6_x2_ff   <= s5_x2_ff;
         s6_x1c_ff  <= s5_x1c_ff;
         s7_b3_ff   <= s7_b3_in;
         s7_x3p_ff  <= s7_x3p_in;
         s8_b4_ff   <= s8_b4_in;
         s8_b7_ff   <= s8_b7_in;
         s9_num_ff  <= s9_num_in;
         s9_den_ff  <= s8_b4_ff;
         s9_big_ff  <= s9_big_in;
         s10_sq_ff  <= s10_sq_in;
         s10_m2_ff  <= s10_m2_in;
         s11_m1_ff  <= 32'(s10_sq_ff * CompC1);
         s11_x2_ff  <= asr32(s10_m2_ff, 16);
         if (s11_ctx_ff.temp_err) begin
            rsp_tenths_ff <= '0;
            rsp_factor_ff <= '0;
            rsp_press_ff  <= '0;
            rsp_err_ff    <= 1'b1;
         end else begin
            rsp_tenths_ff <= s11_ctx_ff.tenths;
            rsp_factor_ff <= s11_ctx_ff.b5;
            rsp_press_ff  <= s11_ctx_ff.press_err ? 18'd0 : s12_press;
            rsp_err_ff    <= s11_ctx_ff.press_err;
         end
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_temp_tenths = rsp_tenths_ff;
   assign rsp_temp_factor = rsp_factor_ff;
   assign rsp_pressure_pa = rsp_press_ff;
   assign rsp_div_error   = rsp_err_ff;

   a_stall_back: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |-> req_stall)
      else $error("Input taken while the result register is stalled.");

   a_temp_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($signed(rsp_temp_tenths) <= 11'sd1000 &&
                     $signed(rsp_temp_tenths) >= -11'sd1000))
      else $error("Temperature result outside its clamp range.");

   a_err_press: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_div_error |-> rsp_pressure_pa == '0)
      else $error("Pressure reported with a zero divisor.");

endmodule

/* dv/pressure_temp_compensation_core_tb.sv */
// Self-checking testbench for the barometric pressure and temperature compensation core.
module pressure_temp_compensation_core_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import ptc_pkg::*;

   typedef struct {
      bit signed [10:0] tenths;
      bit [31:0]        factor;
      bit [17:0]        pascal;
      bit               err;
   } reading_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [15:0] req_raw_temp_word = '0;
   logic [23:0] req_raw_press_word = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic signed [10:0] rsp_temp_tenths;
   logic signed [31:0] rsp_temp_factor;
   logic [17:0] rsp_pressure_pa;
   logic        rsp_div_error;
   logic        csr_wr_en = 1'b0;
   logic [1:0]  csr_index = '0;
   logic [63:0] csr_wr_data = '0;

   bit [63:0] coef_a, coef_b;
   bit [31:0] coef_c;
   bit [1:0]  oss_mode;
   reading_type pending_readings[$];
   int        send_idle_pct, recv_stall_pct, error_count, cycle_count;

   pressure_temp_compensation_core u_dut (.*);

   initial begin
      forever #2 clock = ~clock;
   end

   function automatic bit [31:0] sra(bit [31:0] v, int n);
      return $signed(v) >>> n;
   endfunction

   function automatic bit [31:0] sx16(bit [15:0] v);
      return {{16{v[15]}}, v};
   endfunction

   function automatic reading_type compensate(bit [15:0] ut_raw, bit [23:0] up_raw);
      bit [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
      bit [31:0] ut, up, x1, x2, x3, den, num, b5, b6, sq, acc, b3, b4, b7, p, comp;
      int        t, pr;
      longint    q;
      reading_type r;
      r = '{default: 0};
      ac1 = sx16(coef_a[15:0]);
      ac2 = sx16(coef_a[31:16]);
      ac3 = sx16(coef_a[47:32]);
      ac4 = {16'd0, coef_a[63:48]};
      ac5 = {16'd0, coef_b[15:0]};
      ac6 = {16'd0, coef_b[31:16]};
      b1 = sx16(coef_b[47:32]);
      b2 = sx16(coef_b[63:48]);
      mc = sx16(coef_c[15:0]);
      md = sx16(coef_c[31:16]);
      ut = {16'd0, ut_raw};
      up = {8'd0, up_raw};
      up = up >> (8 - oss_mode);
      acc = (ut - ac6) * ac5;
      x1 = sra(acc, 15);
      den = x1 + md;
      if (den == 0) begin
         r.err = 1'b1;
         return r;
      end
      num = mc << 11;
      q = longint'($signed(num)) / longint'($signed(den));
      x2 = q[31:0];
      b5 = x1 + x2;
      t = $signed(sra(b5 + 32'd8, 4));
      if (t > 1000) t = 1000;
      if (t < -1000) t = -1000;
      r.tenths = t[10:0];
      r.factor = b5;
      b6 = b5 - B6Offset;
      acc = b6 * b6;
      sq = sra(acc, 12);
      acc = b2 * sq;
      x1 = sra(acc, 11);
      acc = ac2 * b6;
      x2 = sra(acc, 11);
      x3 = x1 + x2;
      acc = ac1 * 32'd4 + x3;
      acc = acc << oss_mode;
      b3 = sra(acc + 32'd2, 2);
      acc = ac3 * b6;
      x1 = sra(acc, 13);
      acc = b1 * sq;
      x2 = sra(acc, 16);
      x3 = sra(x1 + x2 + 32'd2, 2);
      acc = ac4 * (x3 + B4Bias);
      b4 = acc >> 15;
      acc = B7Scale >> oss_mode;
      b7 = (up - b3) * acc;
      if (b4 == 0) begin
         r.err = 1'b1;
         return r;
      end
      if (b7 < SignBit) begin
         acc = b7 << 1;
         p = acc / b4;
      end else begin
         acc = b7 / b4;
         p = acc << 1;
      end
      x1 = sra(p, 8) * sra(p, 8);
      acc = x1 * CompC1;
      x1 = sra(acc, 16);
      acc = CompC2 * p;
      x2 = sra(acc, 16);
      comp = p + sra(x1 + x2 + CompC3, 4);
      pr = $signed(comp);
      if (pr < 0) pr = 0;
      if (pr > 262143) pr = 262143;
      r.pascal = pr[17:0];
      return r;
   endfunction

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_stall_pct);
   end

   always @(posedge clock) begin
      reading_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_readings.size() == 0) begin
            $display("%0t: unexpected result tenths=%0d factor=%0d pa=%0d err=%0b", $time,
                     rsp_temp_tenths, rsp_temp_factor, rsp_pressure_pa, rsp_div_error);
            error_count++;
         end else begin
            want = pending_readings.pop_front();
            if (rsp_temp_tenths !== want.tenths) begin
               $display("%0t: temp_tenths expected %0d actual %0d", $time, want.tenths,
                        rsp_temp_tenths);
               error_count++;
            end
            if (rsp_temp_factor !== want.factor) begin
               $display("%0t: temp_factor expected %0d actual %0d", $time,
                        $signed(want.factor), rsp_temp_factor);
               error_count++;
            end
            if (rsp_pressure_pa !== want.pascal) begin
               $display("%0t: pressure_pa expected %0d actual %0d", $time, want.pascal,
                        rsp_pressure_pa);
               error_count++;
            end
            if (rsp_div_error !== want.err) begin
               $display("%0t: div_error expected %0b actual %0b", $time, want.err,
                        rsp_div_error);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > 400000) begin
         $display("FAILURE");
         $finish;
      end
   end

   task automatic send_sample(bit [15:0] ut, bit [23:0] up);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_raw_temp_word <= ut;
      req_raw_press_word <= up;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_readings.push_back(compensate(ut, up));
   endtask

   task automatic drain_pipeline();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_readings.size() != 0) @(posedge clock);
   endtask

   task automatic write_csr(logic [1:0] idx, bit [63:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wr_data <= data;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         CsrCoefA: coef_a = data;
         CsrCoefB: coef_b = data;
         CsrCoefC: coef_c = data[31:0];
         CsrOss: oss_mode = data[1:0];
      endcase
   endtask

   task automatic load_coefs(int ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md, int oss);
      drain_pipeline();
      write_csr(CsrCoefA, {16'(ac4), 16'(ac3), 16'(ac2), 16'(ac1)});
      write_csr(CsrCoefB, {16'(b2), 16'(b1), 16'(ac6), 16'(ac5)});
      write_csr(CsrCoefC, {32'd0, 16'(md), 16'(mc)});
      write_csr(CsrOss, {62'd0, 2'(oss)});
   endtask

   task automatic load_datasheet(int oss);
      load_coefs(408, -72, -14383, 32741, 32757, 23153, 6190, 4, -8711, 2868, oss);
   endtask

   task automatic test_reset_defaults();
      send_sample(16'd27898, 24'h5D2300);
      send_sample(16'hFFFF, 24'hFFFFFF);
   endtask

   task automatic test_datasheet_point();
      for (int m = 0; m < 4; m++) begin
         load_datasheet(m);
         send_sample(16'd27898, 24'd23843 << 8);
         send_sample(16'd0, 24'd0);
         send_sample(16'hFFFF, 24'hFFFFFF);
         send_sample(16'h8000, 24'h800000);
      end
   endtask

   task automatic test_divisor_zero();
      load_coefs(408, -72, -14383, 32741, 0, 23153, 6190, 4, -8711, 0, 0);
      send_sample(16'd27898, 24'h5D2300);
      load_coefs(408, -72, -14383, 0, 32757, 23153, 6190, 4, -8711, 2868, 1);
      send_sample(16'd27898, 24'h5D2300);
   endtask

   task automatic test_extreme_coefs();
      load_coefs(32'h7FFF, 32'h7FFF, 32'h7FFF, 32'hFFFF, 32'hFFFF, 32'h0000, 32'h7FFF,
                 32'h7FFF, 32'h8000, 32'h7FFF, 3);
      send_sample(16'hFFFF, 24'hFFFFFF);
      send_sample(16'd0, 24'd0);
      load_coefs(32'h8000, 32'h8000, 32'h8000, 32'h0001, 32'hFFFF, 32'hFFFF, 32'h8000,
                 32'h8000, 32'h7FFF, 32'h8000, 0);
      send_sample(16'hFFFF, 24'hFFFFFF);
      send_sample(16'd0, 24'h000001);
   endtask

   function automatic int near(int base, int span);
      return base + int'($urandom_range(2 * span)) - span;
   endfunction

   task automatic test_random_traffic(int items);
      int kind;
      for (int blk = 0; blk < items / 100; blk++) begin
         kind = $urandom_range(3);
         if (kind < 2)
            load_coefs(near(408, 300), near(-72, 300), near(-14383, 2000), near(32741, 3000),
                       near(32757, 3000), near(23153, 3000), near(6190, 1000),
                       near(4, 50), near(-8711, 1000), near(2868, 500),
                       $urandom_range(3));
         else
            load_coefs($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                       $urandom, $urandom, $urandom, $urandom, $urandom_range(3));
         for (int i = 0; i < 100; i++) begin
            if ($urandom_range(3) != 0)
               send_sample(16'($urandom_range(20000, 36000)),
                           24'($urandom_range(16777215)));
            else
               send_sample(16'($urandom), 24'($urandom));
         end
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      send_idle_pct = 27;
      recv_stall_pct = 55;
      test_reset_defaults();
      test_datasheet_point();
      test_divisor_zero();
      test_extreme_coefs();
      test_random_traffic(600);
      send_idle_pct = 55;
      recv_stall_pct = 27;
      test_random_traffic(600);
      send_idle_pct = 0;
      recv_stall_pct = 0;
      test_random_traffic(700);
      drain_pipeline();
      repeat (100) @(posedge clock);
      if (error_count == 0 && pending_readings.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
